// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock, disabled in reset
`define ASSERT_IMPL(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("assertion failed");
`endif

// ===== hw/rtl/mrpt_pkg.sv =====
// Package for the Miller-Rabin prime test: widths, base table.
// No dependencies.
package mrpt_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned BaseTableSize = 12;
  localparam int unsigned DefNumBases = 9;

  function automatic logic [5:0] base_value(input logic [3:0] idx);
    logic [5:0] v;
    begin
      unique case (idx)
        4'd0: v = 6'd2;
        4'd1: v = 6'd3;
        4'd2: v = 6'd5;
        4'd3: v = 6'd7;
        4'd4: v = 6'd11;
        4'd5: v = 6'd13;
        4'd6: v = 6'd17;
        4'd7: v = 6'd19;
        4'd8: v = 6'd23;
        4'd9: v = 6'd29;
        4'd10: v = 6'd31;
        4'd11: v = 6'd37;
        default: v = 6'd2;
      endcase
      return v;
    end
  endfunction
endpackage

// ===== hw/rtl/mrpt_modmul.sv =====
// Bit-serial modular multiplier: (x*y) mod m, one bit of y per cycle.
// Uses mrpt_pkg. x, y < m < 2^63.
module mrpt_modmul import mrpt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] x,
  input  logic [WordW-1:0] y,
  input  logic [WordW-1:0] m,
  output logic             done,
  output logic [WordW-1:0] prod
);
  logic [WordW-1:0] acc, yr, xr, mr;
  logic [6:0] cnt;
  logic busy;
  logic [WordW-1:0] dbl, dbl_r, add, add_r;

  always_comb begin
    dbl = {acc[WordW-2:0], 1'b0};
    dbl_r = (dbl >= mr) ? dbl - mr : dbl;
    add = dbl_r + xr;
    add_r = (add >= mr) ? add - mr : add;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc <= '0;
        xr <= x;
        yr <= y;
        mr <= m;
        cnt <= 7'd0;
      end else if (busy) begin
        acc <= yr[WordW-1] ? add_r : dbl_r;
        yr <= {yr[WordW-2:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign prod = acc;
endmodule

// ===== hw/rtl/miller_rabin_prime_test_top.sv =====
// Miller-Rabin prime test, 64-bit signed candidate, one result per request.
// Each modular multiply runs on the single shared modmul; a full prime test takes up
// to min(NUM_BASES, 12) * ~127 multiplies, as the base table holds twelve bases.
// Trivial candidates raise out_valid from S_CHECK, without a multiply. One request at a time.
// Reset: synchronous, clears the sequencer and output valid.
// Uses mrpt_pkg, mrpt_modmul, assert_macros.svh.
`include "assert_macros.svh"
module miller_rabin_prime_test_top import mrpt_pkg::*; #(
  parameter int unsigned NUM_BASES = DefNumBases
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [WordW-1:0] candidate,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    prime_flag
);
  localparam int unsigned NB = (NUM_BASES > BaseTableSize) ? BaseTableSize : NUM_BASES;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_BASE, S_POWSQ_MUL, S_POW_WAIT_R, S_POW_SQ, S_POW_WAIT_B,
    S_CHAIN, S_CHAIN_WAIT, S_NEXT, S_DONE
  } state_t;

  state_t state;
  logic [WordW-1:0] n, d, e, r, b, x, last;
  logic [5:0] s, ri;
  logic [3:0] bi;
  logic seen;
  logic mm_start, mm_done;
  logic [WordW-1:0] mm_x, mm_y, mm_prod;
  logic [WordW-1:0] nm1;
  logic [5:0] bval;
  logic hit;

  assign nm1 = n - 64'd1;
  assign bval = base_value(bi);

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (n == WordW'(base_value(4'(i)))) hit = 1'b1;
    end
  end

  mrpt_modmul u_mul (
    .clk(clk), .rst(rst), .start(mm_start), .x(mm_x), .y(mm_y), .m(n),
    .done(mm_done), .prod(mm_prod)
  );

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      mm_start <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            n <= candidate;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          bi <= '0;
          if (n[WordW-1] || n < 64'd2) begin
            prime_flag <= 1'b0;
            out_valid <= 1'b1;
            state <= S_DONE;
          end else if (hit || NB == 0) begin
            prime_flag <= 1'b1;
            out_valid <= 1'b1;
            state <= S_DONE;
          end else begin
            prime_flag <= 1'b1;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          // base 2 rejects every composite below the larger bases, so any base
          // reached here is below n and needs no reduction
          d <= nm1;
          s <= '0;
          r <= 64'd1;
          b <= WordW'(bval);
          state <= S_POWSQ_MUL;
          e <= '0;
        end
        S_POWSQ_MUL: begin
          // strip factors of two from d first
          if (!d[0] && d != '0 && s < 6'd63) begin
            d <= d >> 1;
            s <= s + 6'd1;
          end else if (e == '0 && d != '0) begin
            e <= d;
            d <= '0;
          end else if (e == '0) begin
            x <= r;
            ri <= '0;
            seen <= 1'b0;
            state <= S_CHAIN;
          end else if (e[0]) begin
            mm_x <= r; mm_y <= b; mm_start <= 1'b1;
            state <= S_POW_WAIT_R;
          end else begin
            state <= S_POW_SQ;
          end
        end
        S_POW_WAIT_R: begin
          if (mm_done) begin
            r <= mm_prod;
            state <= S_POW_SQ;
          end
        end
        S_POW_SQ: begin
          mm_x <= b; mm_y <= b; mm_start <= 1'b1;
          state <= S_POW_WAIT_B;
        end
        S_POW_WAIT_B: begin
          if (mm_done) begin
            b <= mm_prod;
            e <= e >> 1;
            state <= S_POWSQ_MUL;
          end
        end
        S_CHAIN: begin
          if (x != 64'd1) begin
            seen <= 1'b1;
            last <= x;
          end
          if (ri < s) begin
            mm_x <= x; mm_y <= x; mm_start <= 1'b1;
            state <= S_CHAIN_WAIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_CHAIN_WAIT: begin
          if (mm_done) begin
            x <= mm_prod;
            ri <= ri + 6'd1;
            state <= S_CHAIN;
          end
        end
        S_NEXT: begin
          if (seen && last != nm1) begin
            prime_flag <= 1'b0;
            out_valid <= 1'b1;
            state <= S_DONE;
          end else if (32'(bi) + 1 >= NB) begin
            out_valid <= 1'b1;
            state <= S_DONE;
          end else begin
            bi <= bi + 4'd1;
            state <= S_BASE;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_only_done, out_valid, state == S_DONE)
  `ASSERT_IMPL(a_stall_busy, out_valid, in_stall)
  `ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall)
endmodule
